// ===== sv/sorted_priority_task_queue_top_defines.svh =====
// Assertion macros for the sorted priority task queue.
`ifndef SORTED_PRIORITY_TASK_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_TASK_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spq assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spq assertion failed");

`endif

// ===== sv/spq_pkg.sv =====
package spq_pkg;

	localparam int CAPACITY  = 16;
	localparam int TAG_BITS  = 16;
	localparam int PRI_BITS  = 8;
	localparam int IDX_BITS  = $clog2(CAPACITY);
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);
	localparam int OCNT_BITS = 5;
	localparam int OP_BITS   = 2;
	localparam int ST_BITS   = 2;

	localparam logic [OP_BITS-1:0] OP_ADD      = 2'd0;
	localparam logic [OP_BITS-1:0] OP_REMOVE   = 2'd1;
	localparam logic [OP_BITS-1:0] OP_COMPLETE = 2'd2;
	localparam logic [OP_BITS-1:0] OP_QUERY    = 2'd3;

	localparam logic [ST_BITS-1:0] STS_OK       = 2'd0;
	localparam logic [ST_BITS-1:0] STS_NOTFOUND = 2'd1;
	localparam logic [ST_BITS-1:0] STS_EMPTY    = 2'd2;
	localparam logic [ST_BITS-1:0] STS_FULL     = 2'd3;

	typedef struct packed {
		logic [OP_BITS-1:0]  op;
		logic [TAG_BITS-1:0] tag;
		logic [PRI_BITS-1:0] pri;
	} cmd_t;

	typedef struct packed {
		logic [ST_BITS-1:0]   status;
		logic [TAG_BITS-1:0]  tag;
		logic [PRI_BITS-1:0]  pri;
		logic [OCNT_BITS-1:0] tcount;
		logic [OCNT_BITS-1:0] dcount;
		logic                 last;
	} res_t;

endpackage

// ===== sv/spq_front.sv =====
// Command queue: two-entry FIFO between the input port and the table sequencer.
module spq_front import spq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  cmd_t cmd_in,
	output logic cmd_valid,
	input  logic cmd_take,
	output cmd_t cmd_out
);

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_out   = slot_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= cmd_in;
		end
	end

endmodule

// ===== sv/spq_rfifo.sv =====
// Result queue: two-entry FIFO between the sequencer and the output port.
module spq_rfifo import spq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic res_valid,
	output logic res_ready,
	input  res_t res_in,
	output logic empty,
	input  logic pop,
	output res_t res_out
);

	res_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign res_ready = (cnt_q != 2'd2);
	assign empty     = (cnt_q == 2'd0);
	assign res_out   = slot_q[rd_q];
	assign do_push   = res_valid && res_ready;
	assign do_pop    = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= res_in;
		end
	end

endmodule

// ===== sv/spq_back.sv =====
// Table sequencer: sorted entry registers, one entry examined per cycle unless a result is held.
module spq_back import spq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_take,
	input  cmd_t cmd_in,
	output logic res_valid,
	input  logic res_ready,
	output res_t res_out
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ADD    = 3'd1;
	localparam logic [2:0] S_FIND   = 3'd2;
	localparam logic [2:0] S_QFIRST = 3'd3;
	localparam logic [2:0] S_QSCAN  = 3'd4;

	logic [2:0]          state_q;
	cmd_t                cmd_q;
	logic [CNT_BITS-1:0] p_q;
	logic [CNT_BITS-1:0] held_q;
	logic [CNT_BITS-1:0] dcnt_q;
	logic [PRI_BITS-1:0] best_q;
	logic [TAG_BITS-1:0] hold_tag_q;

	logic [TAG_BITS-1:0] tag_q  [CAPACITY];
	logic [PRI_BITS-1:0] pri_q  [CAPACITY];
	logic                done_q [CAPACITY];

	logic [TAG_BITS-1:0] rd_tag;
	logic [PRI_BITS-1:0] rd_pri;
	logic                rd_done;
	logic                at_end;
	logic                is_full;
	logic                add_stop;
	logic                match;

	// control decisions for this cycle
	logic                emit;
	logic                fire;
	logic                do_insert;
	logic                do_remove;
	logic                do_mark;
	logic                step;
	logic                q_hit;
	logic [CNT_BITS-1:0] held_nx;
	logic [CNT_BITS-1:0] dcnt_nx;

	assign rd_tag  = tag_q[p_q[IDX_BITS-1:0]];
	assign rd_pri  = pri_q[p_q[IDX_BITS-1:0]];
	assign rd_done = done_q[p_q[IDX_BITS-1:0]];
	assign at_end  = (p_q == held_q);
	assign is_full = (held_q == CNT_BITS'(CAPACITY));
	// head of equal priority keeps its place; elsewhere insert ahead of equals
	assign add_stop = at_end ||
		((p_q == '0) ? (rd_pri > cmd_q.pri) : (rd_pri >= cmd_q.pri));
	assign match   = (rd_tag == cmd_q.tag);
	assign q_hit   = !rd_done && (rd_pri == best_q);
	assign cmd_take = (state_q == S_IDLE);
	assign fire    = emit && res_ready;

	always_comb begin
		emit      = 1'b0;
		do_insert = 1'b0;
		do_remove = 1'b0;
		do_mark   = 1'b0;
		step      = 1'b0;
		held_nx   = held_q;
		dcnt_nx   = dcnt_q;
		res_out.status = STS_OK;
		res_out.tag    = cmd_q.tag;
		res_out.pri    = cmd_q.pri;
		res_out.last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
			end
			S_ADD: begin
				if (is_full) begin
					emit = 1'b1;
					res_out.status = STS_FULL;
				end else if (add_stop) begin
					emit      = 1'b1;
					do_insert = 1'b1;
					held_nx   = held_q + 1'b1;
				end else begin
					step = 1'b1;
				end
			end
			S_FIND: begin
				res_out.pri = '0;
				if (held_q == '0) begin
					emit = 1'b1;
					res_out.status = STS_EMPTY;
				end else if (at_end) begin
					emit = 1'b1;
					res_out.status = STS_NOTFOUND;
				end else if (match) begin
					emit        = 1'b1;
					res_out.pri = rd_pri;
					if (cmd_q.op == OP_REMOVE) begin
						do_remove = 1'b1;
						held_nx   = held_q - 1'b1;
						if (rd_done && dcnt_q != '0) begin
							dcnt_nx = dcnt_q - 1'b1;
						end
					end else begin
						do_mark = 1'b1;
						if (!rd_done) begin
							dcnt_nx = dcnt_q + 1'b1;
						end
					end
				end else begin
					step = 1'b1;
				end
			end
			S_QFIRST: begin
				res_out.tag = '0;
				res_out.pri = '0;
				if (at_end) begin
					emit = 1'b1;
					res_out.status = STS_EMPTY;
				end else begin
					step = 1'b1;
				end
			end
			S_QSCAN: begin
				res_out.tag = hold_tag_q;
				res_out.pri = best_q;
				if (at_end) begin
					emit = 1'b1;
				end else if (q_hit) begin
					// a later match exists, so the held one is not the last
					emit         = 1'b1;
					res_out.last = 1'b0;
				end else begin
					step = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res_out.tcount = OCNT_BITS'(held_nx);
		res_out.dcount = OCNT_BITS'(dcnt_nx);
	end

	assign res_valid = emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			p_q     <= '0;
			held_q  <= '0;
			dcnt_q  <= '0;
		end else begin
			if (fire) begin
				held_q <= held_nx;
				dcnt_q <= dcnt_nx;
			end
			unique case (state_q)
				S_IDLE: begin
					p_q <= '0;
					if (cmd_valid) begin
						unique case (cmd_in.op)
							OP_ADD:                 state_q <= S_ADD;
							OP_REMOVE, OP_COMPLETE: state_q <= S_FIND;
							OP_QUERY:               state_q <= S_QFIRST;
							default:                state_q <= S_IDLE;
						endcase
					end
				end
				S_ADD, S_FIND: begin
					if (step) begin
						p_q <= p_q + 1'b1;
					end else if (fire) begin
						state_q <= S_IDLE;
					end
				end
				S_QFIRST: begin
					if (fire) begin
						state_q <= S_IDLE;
					end else if (step) begin
						p_q <= p_q + 1'b1;
						if (!rd_done) begin
							state_q <= S_QSCAN;
						end
					end
				end
				S_QSCAN: begin
					if (step) begin
						p_q <= p_q + 1'b1;
					end else if (fire) begin
						if (at_end) begin
							state_q <= S_IDLE;
						end else begin
							p_q <= p_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command latch and query bookkeeping
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			cmd_q <= cmd_in;
		end
		if (state_q == S_QFIRST && step && !rd_done) begin
			best_q     <= rd_pri;
			hold_tag_q <= rd_tag;
		end
		if (state_q == S_QSCAN && fire && !at_end) begin
			hold_tag_q <= rd_tag;
		end
	end

	// entry row: each entry loads from itself, a neighbour or the new command
	always_ff @(posedge clk) begin
		for (int j = 0; j < CAPACITY; j++) begin
			if (fire && do_insert) begin
				if (CNT_BITS'(j) == p_q) begin
					tag_q[j] <= cmd_q.tag;
					pri_q[j] <= cmd_q.pri;
				end else if (CNT_BITS'(j) > p_q && j > 0) begin
					tag_q[j] <= tag_q[(j > 0) ? j - 1 : 0];
					pri_q[j] <= pri_q[(j > 0) ? j - 1 : 0];
				end
			end else if (fire && do_remove) begin
				if (CNT_BITS'(j) >= p_q && j + 1 < CAPACITY) begin
					tag_q[j] <= tag_q[(j + 1 < CAPACITY) ? j + 1 : j];
					pri_q[j] <= pri_q[(j + 1 < CAPACITY) ? j + 1 : j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < CAPACITY; j++) begin
				done_q[j] <= 1'b0;
			end
		end else begin
			for (int j = 0; j < CAPACITY; j++) begin
				if (fire && do_insert) begin
					if (CNT_BITS'(j) == p_q) begin
						done_q[j] <= 1'b0;
					end else if (CNT_BITS'(j) > p_q && j > 0) begin
						done_q[j] <= done_q[(j > 0) ? j - 1 : 0];
					end
				end else if (fire && do_remove) begin
					if (CNT_BITS'(j) >= p_q) begin
						if (j + 1 < CAPACITY) begin
							done_q[j] <= done_q[(j + 1 < CAPACITY) ? j + 1 : j];
						end else begin
							done_q[j] <= 1'b0;
						end
					end
				end else if (fire && do_mark && CNT_BITS'(j) == p_q) begin
					done_q[j] <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== sv/sorted_priority_task_queue_top.sv =====
// Sorted priority task queue.
// Input channel: present opcode, task_tag and priority_req with push; the
// transfer happens on a rising edge with push high and full low. A two-entry
// command queue lets up to two commands wait while the table is busy.
// Output channel: while empty is low the oldest result is on the result ports;
// pop high on a rising edge transfers it. Results wait in a two-entry queue.
// The sequencer takes a command only while idle, then reads a single table
// entry per cycle, holding its place while a result waits for queue room:
//   add            scans to the insert point
//   remove/complete scans for the tag
//   query          scans the table, a listed result leaving in
//                  the cycle its successor is found.
// It takes no new command until it is through with the last one.
// Insert and remove shift the whole entry row as the result is accepted.
// Reset (arst_n low) empties both queues and the table, clears all done marks.
// If the receiver stalls, the result queue fills and the sequencer holds its
// place until space frees; the command queue then fills and raises full.
module sorted_priority_task_queue_top import spq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 push,
	output logic                 full,
	input  logic [OP_BITS-1:0]   opcode,
	input  logic [TAG_BITS-1:0]  task_tag,
	input  logic [PRI_BITS-1:0]  priority_req,
	// result channel
	output logic                 empty,
	input  logic                 pop,
	output logic [ST_BITS-1:0]   status,
	output logic [TAG_BITS-1:0]  result_tag,
	output logic [PRI_BITS-1:0]  result_priority,
	output logic [OCNT_BITS-1:0] task_count,
	output logic [OCNT_BITS-1:0] completed_count,
	output logic                 last
);

	`include "sorted_priority_task_queue_top_defines.svh"

	cmd_t cmd_in;
	cmd_t cmd_head;
	logic cmd_valid;
	logic cmd_take;
	res_t res_back;
	logic res_valid;
	logic res_ready;
	res_t res_head;

	assign cmd_in.op  = opcode;
	assign cmd_in.tag = task_tag;
	assign cmd_in.pri = priority_req;

	// front: command queue
	spq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd_in    (cmd_in),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd_out   (cmd_head)
	);

	// back: sorted table and its sequencer
	spq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd_in    (cmd_head),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_out   (res_back)
	);

	// result queue towards the consumer
	spq_rfifo u_rfifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_in    (res_back),
		.empty     (empty),
		.pop       (pop),
		.res_out   (res_head)
	);

	assign status          = res_head.status;
	assign result_tag      = res_head.tag;
	assign result_priority = res_head.pri;
	assign task_count      = res_head.tcount;
	assign completed_count = res_head.dcount;
	assign last            = res_head.last;

	// completed entries are a subset of held entries
	`SPQ_ASSERT_NOW(a_done_le_held, !empty, completed_count <= task_count)
	// a rejected add only ever comes from a full table
	`SPQ_ASSERT_NOW(a_full_count, !empty && status == STS_FULL,
		task_count == OCNT_BITS'(CAPACITY))
	// only a query listing produces more than one result per command
	`SPQ_ASSERT_NOW(a_err_is_last, !empty && status != STS_OK, last)
	// the sequencer never emits while it is idle taking commands
	`SPQ_ASSERT_NOW(a_no_emit_idle, cmd_take, !res_valid)

endmodule

// ===== verif/tb_sorted_priority_task_queue_top.sv =====
`timescale 1ns / 1ps

module tb_sorted_priority_task_queue_top;
	import spq_pkg::*;

	// Run limit in clock cycles; the slowest correct run is far below this.
	localparam int CYCLE_LIMIT    = 400000;
	// Length of the long receiver hold-off that backs the block up.
	localparam int RX_HOLD_CYCLES = 300;
	// Cycles allowed after the last result for any stray transfer to show.
	localparam int SETTLE_CYCLES  = 40;
	// Cap on mismatch lines so a broken block cannot flood the log.
	localparam int REPORT_CAP     = 40;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic [OP_BITS-1:0]   opcode = '0;
	logic [TAG_BITS-1:0]  task_tag = '0;
	logic [PRI_BITS-1:0]  priority_req = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [ST_BITS-1:0]   status;
	logic [TAG_BITS-1:0]  result_tag;
	logic [PRI_BITS-1:0]  result_priority;
	logic [OCNT_BITS-1:0] task_count;
	logic [OCNT_BITS-1:0] completed_count;
	logic                 last;

	sorted_priority_task_queue_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.opcode          (opcode),
		.task_tag        (task_tag),
		.priority_req    (priority_req),
		.empty           (empty),
		.pop             (pop),
		.status          (status),
		.result_tag      (result_tag),
		.result_priority (result_priority),
		.task_count      (task_count),
		.completed_count (completed_count),
		.last            (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the task table, kept in sorted order exactly as the
	// block should keep it. Only entries below sched_held are meaningful.
	// ------------------------------------------------------------------
	logic [TAG_BITS-1:0] sched_tag  [CAPACITY];
	logic [PRI_BITS-1:0] sched_pri  [CAPACITY];
	bit                  sched_done [CAPACITY];
	int                  sched_held = 0;
	int                  sched_done_cnt = 0;

	// Results still owed by the block, oldest first.
	res_t awaited_results [$];

	// Knobs for the two sides; percentages of cycles spent idle.
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	// Bumped by a test to order one long receiver hold-off.
	int hold_orders = 0;

	// Bookkeeping for the closing summary.
	int mismatches = 0;
	int cmds_accepted = 0;
	int results_checked = 0;
	int adds_rejected = 0;
	int widest_listing = 0;
	int cycle_count = 0;

	// Work out what one accepted command produces and update the shadow table.
	task automatic apply_task_cmd(input logic [OP_BITS-1:0] op,
		input logic [TAG_BITS-1:0] tag, input logic [PRI_BITS-1:0] pri);
		int pos;
		int at;
		int i;
		int first;
		int hits;
		int seen;
		logic [PRI_BITS-1:0] best;
		res_t r;
		r = '0;
		r.tag = tag;
		r.last = 1'b1;
		case (op)
			OP_ADD: begin
				r.pri = pri;
				if (sched_held >= CAPACITY) begin
					r.status = STS_FULL;
					adds_rejected++;
				end else begin
					// An add goes ahead of equals, but never in front of an
					// equal head: it lands just behind it.
					if (sched_held == 0 || sched_pri[0] > pri) begin
						pos = 0;
					end else begin
						pos = 1;
						while (pos < sched_held && sched_pri[pos] < pri)
							pos++;
					end
					for (i = sched_held; i > pos; i--) begin
						sched_tag[i]  = sched_tag[i-1];
						sched_pri[i]  = sched_pri[i-1];
						sched_done[i] = sched_done[i-1];
					end
					sched_tag[pos]  = tag;
					sched_pri[pos]  = pri;
					sched_done[pos] = 1'b0;
					sched_held++;
					r.status = STS_OK;
				end
				r.tcount = OCNT_BITS'(sched_held);
				r.dcount = OCNT_BITS'(sched_done_cnt);
				awaited_results.push_back(r);
			end
			OP_REMOVE, OP_COMPLETE: begin
				at = -1;
				for (i = 0; i < sched_held; i++) begin
					if (at < 0 && sched_tag[i] == tag)
						at = i;
				end
				if (sched_held == 0) begin
					r.status = STS_EMPTY;
				end else if (at < 0) begin
					r.status = STS_NOTFOUND;
				end else begin
					r.status = STS_OK;
					r.pri = sched_pri[at];
					if (op == OP_REMOVE) begin
						// a done entry leaving takes its mark with it
						if (sched_done[at] && sched_done_cnt > 0)
							sched_done_cnt--;
						for (i = at; i + 1 < sched_held; i++) begin
							sched_tag[i]  = sched_tag[i+1];
							sched_pri[i]  = sched_pri[i+1];
							sched_done[i] = sched_done[i+1];
						end
						sched_held--;
						sched_done[sched_held] = 1'b0;
					end else if (!sched_done[at]) begin
						// a repeat completion is counted once only
						sched_done[at] = 1'b1;
						sched_done_cnt++;
					end
				end
				r.tcount = OCNT_BITS'(sched_held);
				r.dcount = OCNT_BITS'(sched_done_cnt);
				awaited_results.push_back(r);
			end
			default: begin
				// query: list every pending entry at the most urgent pending
				// priority, in table order
				first = -1;
				for (i = 0; i < sched_held; i++) begin
					if (first < 0 && !sched_done[i])
						first = i;
				end
				r.tcount = OCNT_BITS'(sched_held);
				r.dcount = OCNT_BITS'(sched_done_cnt);
				if (first < 0) begin
					r.status = STS_EMPTY;
					r.tag = '0;
					awaited_results.push_back(r);
				end else begin
					best = sched_pri[first];
					hits = 0;
					for (i = 0; i < sched_held; i++) begin
						if (!sched_done[i] && sched_pri[i] == best)
							hits++;
					end
					seen = 0;
					for (i = 0; i < sched_held; i++) begin
						if (!sched_done[i] && sched_pri[i] == best) begin
							seen++;
							r.status = STS_OK;
							r.tag = sched_tag[i];
							r.pri = best;
							r.last = (seen == hits);
							awaited_results.push_back(r);
						end
					end
					if (hits > widest_listing)
						widest_listing = hits;
				end
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Sender. Called at a rising edge; returns at the edge of the transfer.
	// push is left high so back-to-back commands need no extra step; idle
	// cycles put junk on the fields with push low.
	// ------------------------------------------------------------------
	task automatic send_cmd(input logic [OP_BITS-1:0] op,
		input logic [TAG_BITS-1:0] tag, input logic [PRI_BITS-1:0] pri);
		while ($urandom_range(99) < tx_idle_pct) begin
			push         <= 1'b0;
			opcode       <= OP_BITS'($urandom);
			task_tag     <= TAG_BITS'($urandom);
			priority_req <= PRI_BITS'($urandom);
			@(posedge clk);
		end
		push         <= 1'b1;
		opcode       <= op;
		task_tag     <= tag;
		priority_req <= pri;
		do
			@(posedge clk);
		while (full);
		cmds_accepted++;
		apply_task_cmd(op, tag, pri);
	endtask

	// Sender goes quiet until every owed result has been popped.
	task automatic wait_drained();
		push <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// Random command shaped by how full the table is, so the fill level
	// wanders between empty and full. Removes and completes mostly name a
	// held tag; adds draw often from a tiny tag pool (duplicates) and low
	// priorities (ties, hence long query listings).
	task automatic pick_random_cmd(output logic [OP_BITS-1:0] op,
		output logic [TAG_BITS-1:0] tag, output logic [PRI_BITS-1:0] pri);
		int roll;
		int add_pct;
		if (sched_held < 4)
			add_pct = 55;
		else if (sched_held >= CAPACITY - 2)
			add_pct = 25;
		else
			add_pct = 35;
		tag = TAG_BITS'($urandom);
		pri = PRI_BITS'($urandom);
		roll = $urandom_range(99);
		if (roll < add_pct) begin
			op = OP_ADD;
			if ($urandom_range(1) == 1)
				tag = TAG_BITS'($urandom_range(7));
			roll = $urandom_range(99);
			if (roll < 60)
				pri = PRI_BITS'($urandom_range(3));
			else if (roll < 68)
				pri = '0;
			else if (roll < 76)
				pri = '1;
		end else begin
			roll = $urandom_range(99);
			if (roll < 25)
				op = OP_QUERY;
			else if (roll < 65)
				op = OP_REMOVE;
			else
				op = OP_COMPLETE;
			if (op != OP_QUERY && sched_held > 0 && $urandom_range(3) != 0)
				tag = sched_tag[$urandom_range(sched_held - 1)];
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver. Pops at random per rx_stall_pct; a hold-off order from a
	// test makes it refuse every result through a long hold-off (RX_HOLD_CYCLES).
	// ------------------------------------------------------------------
	int hold_left = 0;
	int hold_taken = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			hold_left = 0;
			hold_taken = 0;
		end else begin
			if (hold_orders != hold_taken) begin
				hold_taken = hold_orders;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every popped transfer against the oldest expectation.
	// ------------------------------------------------------------------
	function automatic void compare_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			if (mismatches < REPORT_CAP)
				$display("%0t ns: %s mismatch, expected %0h, got %0h",
					$time, what, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (awaited_results.size() == 0) begin
				if (mismatches < REPORT_CAP)
					$display("%0t ns: unexpected result, expected none, got tag %0h status %0d",
						$time, result_tag, status);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				results_checked++;
				compare_field("status", want.status, status);
				compare_field("result_tag", want.tag, result_tag);
				compare_field("result_priority", want.pri, result_priority);
				compare_field("task_count", want.tcount, task_count);
				compare_field("completed_count", want.dcount, completed_count);
				compare_field("last", want.last, last);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t ns: run stopped at cycle limit, %0d results still owed",
				$time, awaited_results.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Everything on an empty table: query has nothing pending, remove and
	// complete report the empty status with the tag echoed.
	task automatic test_empty_table();
		send_cmd(OP_QUERY, 16'h0000, 8'h00);
		send_cmd(OP_REMOVE, 16'hFFFF, 8'hFF);
		send_cmd(OP_COMPLETE, 16'h0000, 8'hFF);
		wait_drained();
	endtask

	// Placement rules: smaller value first, equal-to-head goes just behind
	// the head, otherwise ahead of equals. The query then lists all ties.
	task automatic test_ordering_and_ties();
		send_cmd(OP_ADD, 16'hFFFF, 8'hFF);
		send_cmd(OP_ADD, 16'h0000, 8'h00);
		send_cmd(OP_ADD, 16'h1234, 8'h00);
		send_cmd(OP_ADD, 16'h5555, 8'h00);
		send_cmd(OP_ADD, 16'hAAAA, 8'h80);
		send_cmd(OP_QUERY, 16'hFFFF, 8'hFF);
		wait_drained();
	endtask

	// Missing tag, first and repeat completion, query skipping done entries,
	// and removal of a done entry pulling the done count down.
	task automatic test_completion_rules();
		send_cmd(OP_REMOVE, 16'hBEEF, 8'h00);
		send_cmd(OP_COMPLETE, 16'h0000, 8'h00);
		send_cmd(OP_COMPLETE, 16'h0000, 8'h00);
		send_cmd(OP_QUERY, 16'h0000, 8'h00);
		send_cmd(OP_REMOVE, 16'h0000, 8'h00);
		wait_drained();
	endtask

	// Fill the table to capacity, then one more add is turned away.
	task automatic test_capacity();
		while (sched_held < CAPACITY)
			send_cmd(OP_ADD, TAG_BITS'($urandom), PRI_BITS'($urandom_range(255)));
		send_cmd(OP_ADD, 16'h7FFF, 8'h01);
		wait_drained();
	endtask

	// A burst of random traffic under one idling setting.
	task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
		logic [OP_BITS-1:0]  op;
		logic [TAG_BITS-1:0] tag;
		logic [PRI_BITS-1:0] pri;
		tx_idle_pct = tx_pct;
		rx_stall_pct <= rx_pct;
		repeat (count) begin
			pick_random_cmd(op, tag, pri);
			send_cmd(op, tag, pri);
		end
		wait_drained();
	endtask

	// Receiver refuses everything for a long stretch while the sender keeps
	// offering; result and command queues fill and full must hold the input.
	task automatic test_receiver_hold();
		logic [OP_BITS-1:0]  op;
		logic [TAG_BITS-1:0] tag;
		logic [PRI_BITS-1:0] pri;
		tx_idle_pct = 0;
		rx_stall_pct <= 0;
		hold_orders <= hold_orders + 1;
		for (int k = 0; k < 30; k++) begin
			if (k < 8) begin
				send_cmd(OP_ADD, TAG_BITS'($urandom), 8'h01);
			end else if (k % 3 == 0) begin
				send_cmd(OP_QUERY, TAG_BITS'($urandom), PRI_BITS'($urandom));
			end else begin
				pick_random_cmd(op, tag, pri);
				send_cmd(op, tag, pri);
			end
		end
		wait_drained();
	endtask

	initial begin
		// Reset held low, then released on a rising edge.
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_ordering_and_ties();
		test_completion_rules();
		test_capacity();

		// idling phases: none, sender-heavy, receiver-heavy, light on both
		test_random_traffic(80, 0, 0);
		test_random_traffic(80, 67, 0);
		test_random_traffic(80, 0, 67);
		test_receiver_hold();
		test_random_traffic(80, 10, 10);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d commands and %0d result transfers in %0d cycles.",
			cmds_accepted, results_checked, cycle_count);
		$display("Adds turned away at capacity: %0d; widest query listing: %0d.",
			adds_rejected, widest_listing);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
